// ===== hw/rtl/psp_pkg.sv =====
`default_nettype none

package psp_pkg;

   // parse phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FLAGS  = 3'd1,
      PH_SEPS   = 3'd2,
      PH_ARGIDX = 3'd3,
      PH_WIDTH  = 3'd4,
      PH_PREC   = 3'd5,
      PH_MOD    = 3'd6,
      PH_BEGIN  = 3'd7
   } phase_type;

   // fixed limits
   localparam int unsigned MAX_DIGITS    = 63;
   localparam int unsigned MAX_MODIFIERS = 3;
   localparam logic [30:0] NUM_MAX       = 31'h7FFF_FFFF;
   localparam logic [30:0] IDX_MAX       = 31'd65535;
   localparam logic [16:0] ARGS_MAX      = 17'd65536;
   localparam logic [6:0]  DIGIT_SAT     = 7'd127;
   localparam logic [6:0]  LEN_SAT       = 7'd127;

   // flag bit positions
   localparam int unsigned FB_SPACE  = 0;
   localparam int unsigned FB_ZERO   = 1;
   localparam int unsigned FB_HASH   = 2;
   localparam int unsigned FB_MINUS  = 3;
   localparam int unsigned FB_PLUS   = 4;
   localparam int unsigned FB_QUOTE  = 5;
   localparam int unsigned FB_WFOUND = 6;
   localparam int unsigned FB_WARG   = 7;
   localparam int unsigned FB_WIDX   = 8;
   localparam int unsigned FB_PFOUND = 9;
   localparam int unsigned FB_PARG   = 10;
   localparam int unsigned FB_PIDX   = 11;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_UPPER_L = 8'h4C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_H      = 8'h68;
   localparam logic [7:0] CH_J      = 8'h6A;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_Q      = 8'h71;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_Z      = 8'h7A;

   // one input item
   typedef struct packed {
      logic [7:0] ch;
      logic       spec_start;
      logic       format_start;
   } item_type;

   // one result item
   typedef struct packed {
      logic        status;
      logic [7:0]  conversion;
      logic [11:0] flag_bits;
      logic [7:0]  separator;
      logic [30:0] width;
      logic [30:0] precision;
      logic [15:0] value_index;
      logic [15:0] width_index;
      logic [15:0] precision_index;
      logic [23:0] modifiers;
      logic [6:0]  spec_length;
      logic [16:0] args_used;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/psp_in_reg.sv =====
`default_nettype none

module psp_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire psp_pkg::item_type in_item,
   input  wire logic              out_free,
   output logic                   step,
   output psp_pkg::item_type      item
);
   import psp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // an item moves on when the result side has room
   assign step     = valid_ff & out_free;
   assign in_ready = ~valid_ff | step;
   assign item     = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/psp_parse_core.sv =====
`default_nettype none

module psp_parse_core #(
   parameter int unsigned MAX_SPEC_LEN = 127
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire psp_pkg::item_type item,
   output logic                   emit,
   output psp_pkg::result_type    result
);
   import psp_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_SPEC_LEN + 1);
   localparam int unsigned EXT_W = (POS_W > 7) ? POS_W : 7;

   // state registers
   phase_type        phase_ff, phase_in;
   logic [16:0]      counter_ff, counter_in;
   logic [30:0]      acc_ff, acc_in;
   logic [6:0]       dcount_ff, dcount_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             nopen_ff, nopen_in;
   logic [1:0]       mcount_ff, mcount_in;
   logic [11:0]      flags_ff, flags_in;
   logic [7:0]       sep_ff, sep_in;
   logic [30:0]      width_ff, width_in;
   logic [30:0]      prec_ff, prec_in;
   logic [15:0]      vidx_ff, vidx_in;
   logic [15:0]      widx_ff, widx_in;
   logic [15:0]      pidx_ff, pidx_in;
   logic [23:0]      mods_ff, mods_in;
   logic [16:0]      work_ff, work_in;

   logic [7:0]       ch;
   logic             is_dig;
   logic             is_nz_dig;
   logic [34:0]      prod;
   logic [30:0]      acc_dig;
   logic [6:0]       dcount_dig;
   logic             too_many;
   logic             idx_ok;
   logic             active;
   logic             go;
   logic             err;
   logic             done;
   logic [16:0]      used;
   logic [EXT_W-1:0] len_ext;

   assign ch        = item.ch;
   assign is_dig    = (ch >= CH_0) && (ch <= CH_9);
   assign is_nz_dig = (ch >= CH_1) && (ch <= CH_9);

   // one digit step on the open number: times ten plus digit, saturating
   assign prod       = {4'b0, acc_ff} * 35'd10 + {31'b0, ch[3:0]};
   assign acc_dig    = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[30:0];
   assign dcount_dig = (dcount_ff < DIGIT_SAT) ? dcount_ff + 7'd1 : dcount_ff;

   // evaluation of the open number
   assign too_many = dcount_ff > 7'(MAX_DIGITS);
   assign idx_ok   = !too_many && (acc_ff != 31'd0) && (acc_ff <= IDX_MAX);

   // next state for one character, phases in fall-through order
   always_comb begin
      phase_in   = phase_ff;
      counter_in = counter_ff;
      acc_in     = acc_ff;
      dcount_in  = dcount_ff;
      pos_in     = pos_ff;
      nopen_in   = nopen_ff;
      mcount_in  = mcount_ff;
      flags_in   = flags_ff;
      sep_in     = sep_ff;
      width_in   = width_ff;
      prec_in    = prec_ff;
      vidx_in    = vidx_ff;
      widx_in    = widx_ff;
      pidx_in    = pidx_ff;
      mods_in    = mods_ff;
      work_in    = work_ff;
      active     = 1'b0;
      go         = 1'b0;
      err        = 1'b0;
      done       = 1'b0;
      used       = 17'd0;

      if (step) begin
         // a new specifier clears the record
         if (item.spec_start) begin
            if (item.format_start) begin
               counter_in = 17'd0;
            end
            flags_in  = 12'd0;
            sep_in    = 8'd0;
            width_in  = 31'd0;
            prec_in   = 31'd0;
            vidx_in   = 16'd0;
            widx_in   = 16'd0;
            pidx_in   = 16'd0;
            mods_in   = 24'd0;
            work_in   = counter_in;
            nopen_in  = 1'b0;
            acc_in    = 31'd0;
            dcount_in = 7'd0;
            mcount_in = 2'd0;
            pos_in    = '0;
            phase_in  = PH_BEGIN;
            active    = 1'b1;
         end else begin
            active = (phase_ff != PH_IDLE);
         end
      end

      if (active) begin
         pos_in = pos_in + POS_W'(1);
         if ((ch == CH_NUL) || (pos_in >= POS_W'(MAX_SPEC_LEN))) begin
            err = 1'b1;
         end else begin
            go = 1'b1;
         end
      end

      // leading digits: index or width
      if (go && (phase_in == PH_BEGIN)) begin
         nopen_in = 1'b0;
         if (is_nz_dig) begin
            nopen_in  = 1'b1;
            acc_in    = {27'b0, ch[3:0]};
            dcount_in = 7'd1;
            phase_in  = PH_ARGIDX;
            go        = 1'b0;
         end else begin
            phase_in = PH_FLAGS;
         end
      end

      // flag characters
      if (go && (phase_in == PH_FLAGS)) begin
         go = 1'b0;
         unique case (ch)
            CH_SPACE: flags_in[FB_SPACE] = 1'b1;
            CH_0:     flags_in[FB_ZERO]  = 1'b1;
            CH_HASH:  flags_in[FB_HASH]  = 1'b1;
            CH_MINUS: flags_in[FB_MINUS] = 1'b1;
            CH_PLUS:  flags_in[FB_PLUS]  = 1'b1;
            CH_QUOTE: flags_in[FB_QUOTE] = 1'b1;
            default: begin
               go       = 1'b1;
               phase_in = PH_SEPS;
            end
         endcase
      end

      // grouping separator
      if (go && (phase_in == PH_SEPS)) begin
         phase_in = PH_WIDTH;
         if ((ch == CH_COMMA) || (ch == CH_SEMI) || (ch == CH_COLON) ||
             (ch == CH_UNDER)) begin
            sep_in = ch;
            go     = 1'b0;
         end
      end

      // positional value index
      if (go && (phase_in == PH_ARGIDX)) begin
         if (is_dig) begin
            acc_in    = acc_dig;
            dcount_in = dcount_dig;
            go        = 1'b0;
         end else if (ch == CH_DOLLAR) begin
            go = 1'b0;
            if (!idx_ok) begin
               err = 1'b1;
            end else begin
               vidx_in  = acc_ff[15:0];
               work_in  = {1'b0, acc_ff[15:0]};
               nopen_in = 1'b0;
               phase_in = PH_FLAGS;
            end
         end else begin
            flags_in[FB_WFOUND] = 1'b1;
            phase_in            = PH_WIDTH;
         end
      end

      // width
      if (go && (phase_in == PH_WIDTH)) begin
         if (!nopen_in) begin
            if (ch == CH_STAR) begin
               flags_in[FB_WFOUND] = 1'b1;
               flags_in[FB_WARG]   = 1'b1;
               nopen_in            = 1'b1;
               acc_in              = 31'd0;
               dcount_in           = 7'd0;
               go                  = 1'b0;
            end else if (is_nz_dig) begin
               flags_in[FB_WFOUND] = 1'b1;
               nopen_in            = 1'b1;
               acc_in              = {27'b0, ch[3:0]};
               dcount_in           = 7'd1;
               go                  = 1'b0;
            end
         end else begin
            if (is_dig) begin
               acc_in    = acc_dig;
               dcount_in = dcount_dig;
               go        = 1'b0;
            end else if (ch == CH_DOLLAR) begin
               go = 1'b0;
               if (!flags_in[FB_WARG] || !idx_ok) begin
                  err = 1'b1;
               end else begin
                  flags_in[FB_WIDX] = 1'b1;
                  widx_in           = acc_ff[15:0];
                  work_in           = {1'b0, acc_ff[15:0]};
                  nopen_in          = 1'b0;
                  phase_in          = PH_PREC;
               end
            end else if (!flags_in[FB_WARG]) begin
               if (too_many) begin
                  err = 1'b1;
                  go  = 1'b0;
               end else begin
                  width_in = acc_ff;
               end
            end else if (work_in < ARGS_MAX) begin
               work_in = work_in + 17'd1;
            end
         end
         if (go) begin
            nopen_in = 1'b0;
            phase_in = PH_PREC;
         end
      end

      // precision
      if (go && (phase_in == PH_PREC)) begin
         if (!nopen_in) begin
            if (ch == CH_DOT) begin
               flags_in[FB_PFOUND] = 1'b1;
               nopen_in            = 1'b1;
               acc_in              = 31'd0;
               dcount_in           = 7'd0;
               go                  = 1'b0;
            end
         end else begin
            if (ch == CH_STAR) begin
               go = 1'b0;
               if (flags_in[FB_PARG]) begin
                  err = 1'b1;
               end else begin
                  flags_in[FB_PARG] = 1'b1;
                  acc_in            = 31'd0;
                  dcount_in         = 7'd0;
               end
            end else if (is_dig) begin
               acc_in    = acc_dig;
               dcount_in = dcount_dig;
               go        = 1'b0;
            end else if (ch == CH_DOLLAR) begin
               go = 1'b0;
               if (!flags_in[FB_PARG] || !idx_ok) begin
                  err = 1'b1;
               end else begin
                  flags_in[FB_PIDX] = 1'b1;
                  pidx_in           = acc_ff[15:0];
                  work_in           = {1'b0, acc_ff[15:0]};
                  phase_in          = PH_MOD;
               end
            end else if (!flags_in[FB_PARG]) begin
               if (too_many) begin
                  err = 1'b1;
                  go  = 1'b0;
               end else begin
                  prec_in = acc_ff;
               end
            end else if (work_in < ARGS_MAX) begin
               work_in = work_in + 17'd1;
            end
         end
         if (go) begin
            phase_in = PH_MOD;
         end
      end

      // length modifiers, then the conversion
      if (go && (phase_in == PH_MOD)) begin
         if ((ch == CH_H) || (ch == CH_L) || (ch == CH_J) || (ch == CH_T) ||
             (ch == CH_Z) || (ch == CH_Q) || (ch == CH_UPPER_L)) begin
            if (mcount_in >= 2'(MAX_MODIFIERS)) begin
               err = 1'b1;
            end else begin
               unique case (mcount_in)
                  2'd0:    mods_in[7:0]   = ch;
                  2'd1:    mods_in[15:8]  = ch;
                  2'd2:    mods_in[23:16] = ch;
                  default: mods_in        = mods_in;
               endcase
               mcount_in = mcount_in + 2'd1;
            end
         end else begin
            done = 1'b1;
         end
      end

      // close the specifier
      used = (work_in >= ARGS_MAX) ? ARGS_MAX : work_in + 17'd1;
      if (err || done) begin
         phase_in = PH_IDLE;
      end
      if (done) begin
         counter_in = used;
      end
   end

   // result item
   always_comb begin
      result = '0;
      emit   = err | done;
      if (done) begin
         len_ext                = EXT_W'(pos_in) + EXT_W'(1);
         result.status          = 1'b0;
         result.conversion      = ch;
         result.flag_bits       = flags_in;
         result.separator       = sep_in;
         result.width           = width_in;
         result.precision       = prec_in;
         result.value_index     = vidx_in;
         result.width_index     = widx_in;
         result.precision_index = pidx_in;
         result.modifiers       = mods_in;
         result.args_used       = used;
      end else begin
         len_ext          = EXT_W'(pos_in);
         result.status    = 1'b1;
         result.args_used = counter_in;
      end
      result.spec_length = (len_ext > EXT_W'(LEN_SAT)) ? LEN_SAT : len_ext[6:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         counter_ff <= 17'd0;
      end else begin
         phase_ff   <= phase_in;
         counter_ff <= counter_in;
      end
   end

   // number and record state
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      dcount_ff <= dcount_in;
      pos_ff    <= pos_in;
      nopen_ff  <= nopen_in;
      mcount_ff <= mcount_in;
      flags_ff  <= flags_in;
      sep_ff    <= sep_in;
      width_ff  <= width_in;
      prec_ff   <= prec_in;
      vidx_ff   <= vidx_in;
      widx_ff   <= widx_in;
      pidx_ff   <= pidx_in;
      mods_ff   <= mods_in;
      work_ff   <= work_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/psp_out_reg.sv =====
`default_nettype none

module psp_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                emit,
   input  wire psp_pkg::result_type result,
   input  wire logic                out_ready,
   output logic                     out_valid,
   output logic                     out_free,
   output psp_pkg::result_type      out_item
);
   import psp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type item_ff;

   assign out_valid = valid_ff;
   assign out_free  = ~valid_ff | out_ready;
   assign out_item  = item_ff;

   // valid follows the step, drops when taken
   always_comb begin
      valid_in = valid_ff;
      if (step) begin
         valid_in = emit;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (step & emit) begin
         item_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/printf_spec_parser_unit.sv =====
`default_nettype none
// channel  direction  tdata                              tuser
// req      in         ch                                 spec_start, format_start
// rsp      out        conversion .. args_used (186 bits) status
//
// one character per cycle while the result side has room; an item passes the input
// register, is parsed by one pass of logic with a single times-ten step, and lands in
// the result register when it steps on, a result only for a conversion or an error.
// reset is synchronous: the parser returns to idle, the argument counter to 0.
// a stalled result holds the pipe; req_tready stays high while a slot is free.
module printf_spec_parser_unit #(
   parameter int unsigned MAX_SPEC_LEN = 127
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // ch
   input  wire logic [1:0]   req_tuser,   // spec_start, format_start
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // conversion, flag_bits, separator, width, precision, value_index,
   // width_index, precision_index, modifiers, spec_length, args_used, zero pad
   output logic [191:0]      rsp_tdata,
   output logic [0:0]        rsp_tuser    // status
);
   import psp_pkg::*;

   item_type   in_item;
   item_type   item;
   result_type result;
   result_type out_item;
   logic       step;
   logic       emit;
   logic       out_free;

   assign in_item.ch           = req_tdata;
   assign in_item.spec_start   = req_tuser[0];
   assign in_item.format_start = req_tuser[1];

   // input register
   psp_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .out_free (out_free),
      .step     (step),
      .item     (item)
   );

   // parser state and single-pass logic
   psp_parse_core #(
      .MAX_SPEC_LEN (MAX_SPEC_LEN)
   ) u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   // result register
   psp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .emit      (emit),
      .result    (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_free  (out_free),
      .out_item  (out_item)
   );

   // pack the result item
   assign rsp_tdata = {6'b0,
                       out_item.args_used,
                       out_item.spec_length,
                       out_item.modifiers,
                       out_item.precision_index,
                       out_item.width_index,
                       out_item.value_index,
                       out_item.precision,
                       out_item.width,
                       out_item.separator,
                       out_item.flag_bits,
                       out_item.conversion};
   assign rsp_tuser = out_item.status;

endmodule

`default_nettype wire
